### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on the same edge as its antecedent
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// property holds on the edge after its antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/ams_pkg.sv
// ----------------------------------------------------------------------------
// ams_pkg
// shared types and constants of the autonomous mode supervisor
// ----------------------------------------------------------------------------
package ams_pkg;

   // configuration register indexes
   localparam int CsrIdxWidth = 1;
   localparam logic [CsrIdxWidth-1:0] CSR_STOP_SPEED = 1'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_HEARTBEAT  = 1'd1;

   localparam logic [15:0] STOP_SPEED_RESET = 16'd1;
   localparam logic [31:0] HEARTBEAT_RESET  = 32'd500000;

   // steering handshake states
   typedef enum logic [2:0] {
      STEER_RESET  = 3'd0,
      STEER_INIT   = 3'd1,
      STEER_WAIT   = 3'd2,
      STEER_ARMED  = 3'd3,
      STEER_ENGAGE = 3'd4,
      STEER_ACTIVE = 3'd5
   } steer_state_type;

   // vehicle steering status codes
   localparam logic [3:0] STS_READY   = 4'd3;
   localparam logic [3:0] STS_ANGLE   = 4'd4;
   localparam logic [3:0] STS_FAULT_A = 4'd6;
   localparam logic [3:0] STS_FAULT_B = 4'd7;

   // competition flag range
   localparam logic [2:0] COMP_LOW  = 3'd1;
   localparam logic [2:0] COMP_HIGH = 3'd3;

   typedef struct packed {
      logic ready;
      logic lateral;
      logic longitudinal;
      logic run;
   } flags_type;

   typedef struct packed {
      logic        mode_msg_valid;
      logic        manual_request;
      logic        operation_request;
      logic        lateral_request;
      logic        longitudinal_request;
      logic [2:0]  emergency_flag;
      logic [15:0] wheel_speed_fl;
      logic        brake_active;
      logic [3:0]  steer_status;
      logic [7:0]  health_seq;
      logic [31:0] tick_time_us;
   } req_type;

   typedef struct packed {
      flags_type  flags;
      logic       healthy;
      logic [2:0] steer_state;
   } rsp_type;

endpackage

### sv/ams_req_if.sv
// ----------------------------------------------------------------------------
// ams_req_if
// tick transaction channel into the supervisor
// ----------------------------------------------------------------------------
interface ams_req_if;
   logic        valid;
   logic        ready;
   logic        mode_msg_valid;
   logic        manual_request;
   logic        operation_request;
   logic        lateral_request;
   logic        longitudinal_request;
   logic [2:0]  emergency_flag;
   logic [15:0] wheel_speed_fl;
   logic        brake_active;
   logic [3:0]  steer_status;
   logic [7:0]  health_seq;
   logic [31:0] tick_time_us;

   modport source (
      output valid, mode_msg_valid, manual_request, operation_request,
             lateral_request, longitudinal_request, emergency_flag,
             wheel_speed_fl, brake_active, steer_status, health_seq, tick_time_us,
      input  ready
   );

   modport sink (
      input  valid, mode_msg_valid, manual_request, operation_request,
             lateral_request, longitudinal_request, emergency_flag,
             wheel_speed_fl, brake_active, steer_status, health_seq, tick_time_us,
      output ready
   );
endinterface

### sv/ams_rsp_if.sv
// ----------------------------------------------------------------------------
// ams_rsp_if
// result transaction channel out of the supervisor
// ----------------------------------------------------------------------------
interface ams_rsp_if;
   logic       valid;
   logic       ready;
   logic       ad_ready;
   logic       lateral_enabled;
   logic       longitudinal_enabled;
   logic       run_user_command;
   logic       command_healthy;
   logic [2:0] steer_request_state;

   modport source (
      output valid, ad_ready, lateral_enabled, longitudinal_enabled,
             run_user_command, command_healthy, steer_request_state,
      input  ready
   );

   modport sink (
      input  valid, ad_ready, lateral_enabled, longitudinal_enabled,
             run_user_command, command_healthy, steer_request_state,
      output ready
   );
endinterface

### sv/ams_mode.sv
// ----------------------------------------------------------------------------
// ams_mode
// mode request rules, competition latch and brake override
// ----------------------------------------------------------------------------
module ams_mode (
   input  ams_pkg::req_type   req,
   input  ams_pkg::flags_type cur,
   input  logic               healthy_prev,
   input  logic [15:0]        stop_limit,
   output ams_pkg::flags_type nxt
);

   logic comp;
   logic stopped;

   assign comp    = (req.emergency_flag >= ams_pkg::COMP_LOW) &&
                    (req.emergency_flag <= ams_pkg::COMP_HIGH);
   assign stopped = req.wheel_speed_fl < stop_limit;

   always_comb begin
      ams_pkg::flags_type f;
      logic skip_latch;
      f          = cur;
      skip_latch = 1'b0;

      if (req.mode_msg_valid) begin
         if (req.manual_request) begin
            f          = '0;
            skip_latch = 1'b1;
         end else begin
            if (req.operation_request && !f.ready && stopped) begin
               f.ready = 1'b1;
            end
            if (!f.ready) begin
               f.lateral      = 1'b0;
               f.longitudinal = 1'b0;
               skip_latch     = 1'b1;
            end else begin
               if (req.lateral_request && stopped) begin
                  f.lateral = 1'b1;
               end
               if (req.longitudinal_request && stopped) begin
                  f.longitudinal = 1'b1;
               end
               if (f.lateral && f.longitudinal) begin
                  f.run = 1'b1;
               end
            end
         end
      end

      // competition latch
      if (!skip_latch && f.run && comp) begin
         f.ready        = 1'b1;
         f.lateral      = 1'b1;
         f.longitudinal = 1'b1;
      end

      // brake override
      if ((f.lateral || f.longitudinal) && req.brake_active) begin
         f.longitudinal = 1'b0;
         if (!comp) begin
            f.run     = 1'b0;
            f.lateral = 1'b0;
         end
      end

      // brake while unhealthy, health from the previous tick
      if (!healthy_prev && f.ready && req.brake_active) begin
         f.ready        = 1'b0;
         f.lateral      = 1'b0;
         f.longitudinal = 1'b0;
         if (!comp) begin
            f.run = 1'b0;
         end
      end

      nxt = f;
   end

endmodule

### sv/ams_health.sv
// ----------------------------------------------------------------------------
// ams_health
// heartbeat sequence tracking and timeout check
// ----------------------------------------------------------------------------
module ams_health (
   input  logic [7:0]  last_seq,
   input  logic [31:0] last_time,
   input  logic [7:0]  seq,
   input  logic [31:0] now,
   input  logic [31:0] timeout,
   output logic        seq_changed,
   output logic        healthy
);

   logic [31:0] diff;

   assign seq_changed = last_seq != seq;
   // absolute difference, time going backwards counts too
   assign diff = (last_time > now) ? (last_time - now) : (now - last_time);
   // a fresh sequence restarts the timer and counts as healthy whatever the difference
   assign healthy = seq_changed || (diff <= timeout);

endmodule

### sv/ams_steer.sv
// ----------------------------------------------------------------------------
// ams_steer
// steering handshake next state
// ----------------------------------------------------------------------------
module ams_steer (
   input  logic                     lateral,
   input  ams_pkg::steer_state_type state,
   input  logic [3:0]               status,
   output ams_pkg::steer_state_type nxt
);

   always_comb begin
      nxt = state;
      if (!lateral) begin
         nxt = ams_pkg::STEER_INIT;
      end else begin
         unique case (state)
            ams_pkg::STEER_INIT: begin
               nxt = ams_pkg::STEER_WAIT;
            end
            ams_pkg::STEER_WAIT: begin
               if (status <= ams_pkg::STS_READY || status == ams_pkg::STS_FAULT_A ||
                   status == ams_pkg::STS_FAULT_B) begin
                  nxt = ams_pkg::STEER_ARMED;
               end
            end
            ams_pkg::STEER_ARMED: begin
               if (status == ams_pkg::STS_READY) begin
                  nxt = ams_pkg::STEER_ENGAGE;
               end
            end
            ams_pkg::STEER_ENGAGE: begin
               if (status == ams_pkg::STS_ANGLE) begin
                  nxt = ams_pkg::STEER_ACTIVE;
               end
            end
            ams_pkg::STEER_ACTIVE: begin
               if (status == ams_pkg::STS_FAULT_A || status == ams_pkg::STS_FAULT_B ||
                   status == ams_pkg::STS_READY) begin
                  nxt = ams_pkg::STEER_INIT;
               end
            end
            default: begin
               nxt = ams_pkg::STEER_INIT;
            end
         endcase
      end
   end

endmodule

### sv/autonomous_mode_supervisor_unit.sv
// ----------------------------------------------------------------------------
// autonomous_mode_supervisor_unit
// mode flags, brake override, heartbeat health and steering handshake
// ----------------------------------------------------------------------------
// One tick transaction in, one result transaction out. Each tick is captured
// in an input register; once the output register is free or being drained,
// the mode rules, brake override, heartbeat check and steering step are
// evaluated against the supervisor state, and the state is updated and the
// result loaded into the output register in the same cycle.
// A new tick is accepted every cycle as long as results are taken: the
// output register decouples the result side, so throughput is one
// transaction per clock. The two csr registers (stop speed limit, heartbeat
// timeout) are to be written by the user only while the block is idle, which
// the block itself does not enforce; they take effect for the next tick.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module autonomous_mode_supervisor_unit (
   input  logic                                clock,
   input  logic                                reset,
   ams_req_if.sink                             req_chan,
   ams_rsp_if.source                           rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [ams_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [31:0]                         csr_wr_data
);

   // csr registers
   logic [15:0] stop_limit_ff;
   logic [31:0] timeout_ff;

   // input stage
   logic             in_valid_ff;
   ams_pkg::req_type in_data_ff;

   // output stage
   logic             out_valid_ff;
   ams_pkg::rsp_type out_data_ff;
   ams_pkg::rsp_type out_data_in;

   // supervisor state
   ams_pkg::flags_type       flags_ff, flags_in;
   logic                     healthy_ff, healthy_in;
   logic [7:0]               last_seq_ff, last_seq_in;
   logic [31:0]              last_time_ff, last_time_in;
   ams_pkg::steer_state_type steer_ff, steer_in;

   // combinational results
   ams_pkg::flags_type       flags_calc;
   logic                     seq_changed;
   logic                     healthy_calc;
   ams_pkg::steer_state_type steer_calc;

   logic adv;

   // input stage moves on when the output register is free or being drained
   assign adv            = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || adv;

   // csr write port
   always_ff @(posedge clock) begin
      if (reset) begin
         stop_limit_ff <= ams_pkg::STOP_SPEED_RESET;
         timeout_ff    <= ams_pkg::HEARTBEAT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ams_pkg::CSR_STOP_SPEED: stop_limit_ff <= csr_wr_data[15:0];
            ams_pkg::CSR_HEARTBEAT:  timeout_ff    <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_data_ff.mode_msg_valid       <= req_chan.mode_msg_valid;
         in_data_ff.manual_request       <= req_chan.manual_request;
         in_data_ff.operation_request    <= req_chan.operation_request;
         in_data_ff.lateral_request      <= req_chan.lateral_request;
         in_data_ff.longitudinal_request <= req_chan.longitudinal_request;
         in_data_ff.emergency_flag       <= req_chan.emergency_flag;
         in_data_ff.wheel_speed_fl       <= req_chan.wheel_speed_fl;
         in_data_ff.brake_active         <= req_chan.brake_active;
         in_data_ff.steer_status         <= req_chan.steer_status;
         in_data_ff.health_seq           <= req_chan.health_seq;
         in_data_ff.tick_time_us         <= req_chan.tick_time_us;
      end
   end

   // mode rules and brake override, brake check uses last tick's health
   ams_mode u_mode (
      .req          (in_data_ff),
      .cur          (flags_ff),
      .healthy_prev (healthy_ff),
      .stop_limit   (stop_limit_ff),
      .nxt          (flags_calc)
   );

   // heartbeat timeout
   ams_health u_health (
      .last_seq    (last_seq_ff),
      .last_time   (last_time_ff),
      .seq         (in_data_ff.health_seq),
      .now         (in_data_ff.tick_time_us),
      .timeout     (timeout_ff),
      .seq_changed (seq_changed),
      .healthy     (healthy_calc)
   );

   // steering handshake follows the lateral flag after override
   ams_steer u_steer (
      .lateral (flags_calc.lateral),
      .state   (steer_ff),
      .status  (in_data_ff.steer_status),
      .nxt     (steer_calc)
   );

   // state next values, held unless a tick is processed
   always_comb begin
      flags_in     = flags_ff;
      healthy_in   = healthy_ff;
      last_seq_in  = last_seq_ff;
      last_time_in = last_time_ff;
      steer_in     = steer_ff;
      if (adv) begin
         flags_in   = flags_calc;
         healthy_in = healthy_calc;
         steer_in   = steer_calc;
         if (seq_changed) begin
            last_seq_in  = in_data_ff.health_seq;
            last_time_in = in_data_ff.tick_time_us;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         healthy_ff   <= 1'b0;
         last_seq_ff  <= '0;
         last_time_ff <= '0;
         steer_ff     <= ams_pkg::STEER_RESET;
      end else begin
         flags_ff     <= flags_in;
         healthy_ff   <= healthy_in;
         last_seq_ff  <= last_seq_in;
         last_time_ff <= last_time_in;
         steer_ff     <= steer_in;
      end
   end

   // result register
   always_comb begin
      out_data_in.flags       = flags_calc;
      out_data_in.healthy     = healthy_calc;
      out_data_in.steer_state = steer_calc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_chan.valid                = out_valid_ff;
   assign rsp_chan.ad_ready             = out_data_ff.flags.ready;
   assign rsp_chan.lateral_enabled      = out_data_ff.flags.lateral;
   assign rsp_chan.longitudinal_enabled = out_data_ff.flags.longitudinal;
   assign rsp_chan.run_user_command     = out_data_ff.flags.run;
   assign rsp_chan.command_healthy      = out_data_ff.healthy;
   assign rsp_chan.steer_request_state  = out_data_ff.steer_state;

   // an axis is never enabled without ready
   `ASSERT_SAME(a_axis_needs_ready, clock, reset, flags_ff.lateral || flags_ff.longitudinal, flags_ff.ready, "axis enabled without ready")

   // every processed tick leaves the handshake in its legal range
   `ASSERT_NEXT(a_steer_range, clock, reset, adv, steer_ff >= ams_pkg::STEER_INIT && steer_ff <= ams_pkg::STEER_ACTIVE, "steering state out of range")

   // a processed tick always shows up as a pending result
   `ASSERT_NEXT(a_result_loaded, clock, reset, adv, out_valid_ff && out_data_ff.steer_state == steer_ff, "result not loaded")

endmodule
